// ===== hw/rtl/rapp_pkg.sv =====
// Package with the shared types and constants of the redundant audio payload parser.
package rapp_pkg;

	localparam int DefMaxBlocks = 16;

	localparam logic [7:0] HdrFollowMask = 8'h80;
	localparam logic [7:0] HdrTypeMask   = 8'h7f;
	localparam logic [7:0] HdrLenHiMask  = 8'h03;

	localparam int InTdataW  = 56;
	localparam int OutTdataW = 72;
	localparam int KindW     = 2;

	typedef enum logic [1:0] {
		KIND_DESC   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HEAD = 2'd1,
		PH_DATA = 2'd2,
		PH_DROP = 2'd3
	} parse_phase_t;

	typedef enum logic [2:0] {
		ST_IN    = 3'd0,
		ST_DREAD = 3'd1,
		ST_DEMIT = 3'd2,
		ST_PRIM  = 3'd3,
		ST_SREAD = 3'd4,
		ST_SCHK  = 3'd5
	} seq_state_t;

endpackage

// ===== hw/rtl/redundant_audio_payload_parser.sv =====
// Top level of the redundant audio payload parser: header collection, descriptors, data tagging, rejects.
// The parser takes one packet byte per beat while it collects headers and passes data bytes.
// After the primary header it stalls its input for the descriptor burst, with one header
// store read for each redundant descriptor and none for the primary.
// After the burst, and after each finished block, it looks up the length of the next block
// that holds data, checking one redundant block at a time through the single read port of
// the header store until it finds one or reaches the primary.
// Results leave through a one-beat output register, so a new byte is taken while a result waits
// as long as the downstream side takes it in the same cycle.
module redundant_audio_payload_parser #(
	parameter int MAX_BLOCKS = rapp_pkg::DefMaxBlocks
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: payload_byte[8], packet_length[16], rtp_timestamp[32].
	input  logic [rapp_pkg::InTdataW-1:0]  s_tdata,
	// Fields from bit 0: first_of_packet[1].
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: block_index[5], block_type[7], block_timestamp[32],
	// block_length[16], data_out[8], last_of_block[1], zero fill[3].
	output logic [rapp_pkg::OutTdataW-1:0] m_tdata,
	// Fields from bit 0: kind[2].
	output logic [rapp_pkg::KindW-1:0]     m_tuser,
	output logic                           m_tlast
);
	import rapp_pkg::*;

	localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int LSW = $clog2(MAX_BLOCKS * 1023 + 1);

	logic [30:0] mem [MAX_BLOCKS];
	logic [30:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic we;
	logic [AW-1:0] wr_addr;
	logic [30:0] wr_data;

	seq_state_t state_q, state_d;
	parse_phase_t phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [1:0] hbp_q, hbp_d;
	logic [23:0] asm_q, asm_d;
	logic [15:0] rem_q, rem_d;
	logic [LSW-1:0] sum_q, sum_d;
	logic [CW-1:0] cur_q, cur_d;
	logic [15:0] left_q, left_d;
	logic [31:0] ts_q, ts_d;
	logic [6:0] ptype_q, ptype_d;
	logic [CW-1:0] idx_q, idx_d;

	logic out_free;
	logic emit;
	kind_t e_kind;
	logic [4:0] e_idx;
	logic [6:0] e_type;
	logic [31:0] e_ts;
	logic [15:0] e_len;
	logic [7:0] e_data;
	logic e_lob;
	logic e_lor;

	logic m_valid_q;
	logic [OutTdataW-1:0] m_tdata_q;
	logic [KindW-1:0] m_tuser_q;
	logic m_tlast_q;

	logic [7:0] in_byte;
	logic [15:0] in_len;
	logic [31:0] in_ts;
	logic accept;
	logic [15:0] rem1;
	logic [15:0] left1;
	logic [9:0] new_len;
	logic [13:0] new_off;

	assign in_byte = s_tdata[7:0];
	assign in_len  = s_tdata[23:8];
	assign in_ts   = s_tdata[55:24];
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IN) && out_free;
	assign accept = s_tvalid && s_tready;
	assign rd_addr = ((state_q == ST_DREAD) || (state_q == ST_DEMIT)) ? idx_q[AW-1:0]
	                                                                  : cur_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		count_d = count_q;
		hbp_d = hbp_q;
		asm_d = asm_q;
		rem_d = rem_q;
		sum_d = sum_q;
		cur_d = cur_q;
		left_d = left_q;
		ts_d = ts_q;
		ptype_d = ptype_q;
		idx_d = idx_q;
		we = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = 31'd0;
		emit = 1'b0;
		e_kind = KIND_DESC;
		e_idx = 5'd0;
		e_type = 7'd0;
		e_ts = 32'd0;
		e_len = 16'd0;
		e_data = 8'd0;
		e_lob = 1'b0;
		e_lor = 1'b0;
		rem1 = 16'd0;
		left1 = 16'd0;
		new_len = {asm_q[1:0], in_byte};
		new_off = {asm_q[15:8], asm_q[7:2]};
		case (state_q)
			ST_IN: begin
				if (accept) begin
					if (s_tuser) begin
						count_d = '0;
						hbp_d = 2'd0;
						asm_d = 24'd0;
						sum_d = '0;
						cur_d = '0;
						left_d = 16'd0;
						rem_d = in_len;
						ts_d = in_ts;
						phase_d = PH_HEAD;
					end
					if (s_tuser && (in_len == 16'd0)) begin
						emit = 1'b1;
						e_kind = KIND_REJECT;
						e_lor = 1'b1;
						phase_d = PH_IDLE;
					end else if (phase_d == PH_IDLE) begin
						phase_d = PH_IDLE;
					end else if (rem_d == 16'd0) begin
						phase_d = PH_IDLE;
					end else begin
						rem1 = rem_d - 16'd1;
						rem_d = rem1;
						case (phase_d)
							PH_DROP: begin
								if (rem1 == 16'd0) begin
									phase_d = PH_IDLE;
								end
							end
							PH_DATA: begin
								emit = 1'b1;
								e_kind = KIND_DATA;
								e_idx = 5'(cur_q);
								e_data = in_byte;
								e_lob = (left_q <= 16'd1);
								e_lor = 1'b1;
								left1 = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
								left_d = left1;
								if (rem1 == 16'd0) begin
									phase_d = PH_IDLE;
								end else if (left1 == 16'd0) begin
									cur_d = cur_q + CW'(1);
									state_d = ST_SREAD;
								end
							end
							PH_HEAD: begin
								case (hbp_d)
									2'd0: begin
										if ((in_byte & HdrFollowMask) == 8'd0) begin
											ptype_d = 7'(in_byte & HdrTypeMask);
											if (rem1 < 16'(sum_d)) begin
												emit = 1'b1;
												e_kind = KIND_REJECT;
												e_lor = 1'b1;
												phase_d = (rem1 != 16'd0) ? PH_DROP : PH_IDLE;
											end else begin
												phase_d = PH_DATA;
												idx_d = '0;
												state_d = (count_d == '0) ? ST_PRIM : ST_DREAD;
											end
										end else if ((count_d >= CW'(MAX_BLOCKS)) ||
										             (rem1 < 16'd4)) begin
											emit = 1'b1;
											e_kind = KIND_REJECT;
											e_lor = 1'b1;
											phase_d = (rem1 != 16'd0) ? PH_DROP : PH_IDLE;
										end else begin
											asm_d = {in_byte, 16'd0};
											hbp_d = 2'd1;
										end
									end
									2'd1: begin
										asm_d = asm_q | {8'd0, in_byte, 8'd0};
										hbp_d = 2'd2;
									end
									2'd2: begin
										asm_d = asm_q | {16'd0, in_byte};
										hbp_d = 2'd3;
									end
									default: begin
										we = (count_q < CW'(MAX_BLOCKS));
										wr_data = {asm_q[22:16], new_off, new_len};
										count_d = count_q + CW'(1);
										sum_d = sum_q + LSW'(new_len);
										hbp_d = 2'd0;
										asm_d = 24'd0;
									end
								endcase
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
			end
			ST_DREAD: begin
				state_d = ST_DEMIT;
			end
			ST_DEMIT: begin
				if (out_free) begin
					emit = 1'b1;
					e_kind = KIND_DESC;
					e_idx = 5'(idx_q);
					e_type = rd_data_q[30:24];
					e_ts = ts_q - {18'd0, rd_data_q[23:10]};
					e_len = {6'd0, rd_data_q[9:0]};
					idx_d = idx_q + CW'(1);
					state_d = ((idx_q + CW'(1)) < count_q) ? ST_DREAD : ST_PRIM;
				end
			end
			ST_PRIM: begin
				if (out_free) begin
					emit = 1'b1;
					e_kind = KIND_DESC;
					e_idx = 5'(count_q);
					e_type = ptype_q;
					e_ts = ts_q;
					e_len = rem_q - 16'(sum_q);
					e_lor = 1'b1;
					cur_d = '0;
					state_d = ST_SREAD;
				end
			end
			ST_SREAD: begin
				if (cur_q < count_q) begin
					state_d = ST_SCHK;
				end else begin
					left_d = rem_q;
					if (rem_q == 16'd0) begin
						phase_d = PH_IDLE;
					end
					state_d = ST_IN;
				end
			end
			ST_SCHK: begin
				if (rd_data_q[9:0] != 10'd0) begin
					left_d = {6'd0, rd_data_q[9:0]};
					state_d = ST_IN;
				end else begin
					cur_d = cur_q + CW'(1);
					state_d = ST_SREAD;
				end
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
			phase_q <= PH_IDLE;
			count_q <= '0;
			hbp_q <= 2'd0;
			asm_q <= 24'd0;
			rem_q <= 16'd0;
			sum_q <= '0;
			cur_q <= '0;
			left_q <= 16'd0;
			ts_q <= 32'd0;
			ptype_q <= 7'd0;
			idx_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
			hbp_q <= hbp_d;
			asm_q <= asm_d;
			rem_q <= rem_d;
			sum_q <= sum_d;
			cur_q <= cur_d;
			left_q <= left_d;
			ts_q <= ts_d;
			ptype_q <= ptype_d;
			idx_q <= idx_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {3'd0, e_lob, e_data, e_len, e_ts, e_type, e_idx};
			m_tuser_q <= e_kind;
			m_tlast_q <= e_lor;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

endmodule
